// ===== hw/rtl/ishtab_pkg.sv =====
// Shared constants, opcodes and status codes for the interpolation search table.
// No dependencies.
`timescale 1ns / 1ps
package ishtab_pkg;
    localparam int TableDepth = 1024;
    localparam int AddrW = $clog2(TableDepth);
    localparam int CountW = AddrW + 1;
    localparam int KeyW = 64;
    localparam int ProbeW = 11;
    localparam int PosW = 10;
    // product width: span count (CountW bits) times 64-bit distance
    localparam int ProdW = KeyW + CountW;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
endpackage

// ===== hw/rtl/ishtab_div.sv =====
// Restoring divider for floor(prod / key distance), one quotient bit per cycle.
// Depends on ishtab_pkg.
`timescale 1ns / 1ps
module ishtab_div
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [ishtab_pkg::ProdW-1:0]    dividend,
    input  logic [ishtab_pkg::KeyW-1:0]     divisor,
    output logic                            done,
    output logic [ishtab_pkg::ProdW-1:0]    quotient
);
    localparam int CntW = $clog2(ishtab_pkg::ProdW + 1);
    logic [ishtab_pkg::ProdW-1:0] quo_reg, quo_next;
    logic [ishtab_pkg::KeyW:0] rem_reg, rem_next;
    logic [ishtab_pkg::KeyW-1:0] dvs_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [ishtab_pkg::KeyW:0] shifted;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted = {rem_reg[ishtab_pkg::KeyW-1:0], quo_reg[ishtab_pkg::ProdW-1]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CntW'(ishtab_pkg::ProdW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = shifted - {1'b0, dvs_reg};
                quo_next = {quo_reg[ishtab_pkg::ProdW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[ishtab_pkg::ProdW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== hw/rtl/interpolation_search_hash_table.sv =====
// Top level: key store memory, search sequencer and output register.
// Depends on ishtab_pkg and ishtab_div.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_valid/in_ready carries op and key; output channel
//   out_valid/out_ready carries status, position and probe_count, one result
//   per input transfer, in order.
//   Clear, append and unused opcodes go from S_IDLE through S_EMIT, which
//   writes the result to the output register. Each lookup probe reads the
//   first and last entries, multiplies, runs the bit-serial divider (one
//   quotient bit per cycle) when the span is nonzero, and reads and compares
//   the middle entry; S_FIN makes the closing check and S_EMIT the result.
//   An interpolation search needs few probes on evenly spread keys and up to
//   the entry count in the worst case. The key memory, read once per cycle,
//   and the divider set the lookup time.
//   One item is in work at a time. The result sits in an output register;
//   the next item is taken while it waits, and the sequencer holds before
//   writing a new result until the receiver takes the old one.
//   Reset empties the table at once (entry count to zero); no clearing pass.
module interpolation_search_hash_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [63:0] key,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [9:0]  position,
    output logic [10:0] probe_count
);
    localparam int AW = ishtab_pkg::AddrW;
    localparam int CW = ishtab_pkg::CountW;
    localparam int KW = ishtab_pkg::KeyW;
    localparam int PW = ishtab_pkg::ProdW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDF = 4'd1;
    localparam logic [3:0] S_RDL = 4'd2;
    localparam logic [3:0] S_GETF = 4'd3;
    localparam logic [3:0] S_GETL = 4'd4;
    localparam logic [3:0] S_MUL = 4'd5;
    localparam logic [3:0] S_DIV = 4'd6;
    localparam logic [3:0] S_RDM = 4'd7;
    localparam logic [3:0] S_CMP = 4'd8;
    localparam logic [3:0] S_FIN = 4'd9;
    localparam logic [3:0] S_EMIT = 4'd10;

    logic [KW-1:0] mem [ishtab_pkg::TableDepth];
    logic [KW-1:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic wr_en;

    logic [3:0] state_reg, state_next;
    logic [KW-1:0] key_reg;
    logic [CW-1:0] count_reg, count_next;
    // first/last kept one wider and offset-free; signed compare via CW+1 bits
    logic signed [CW:0] first_reg, first_next, last_reg, last_next, mid_reg, mid_next;
    logic [KW-1:0] kf_reg, kf_next, kl_reg, kl_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [ishtab_pkg::ProbeW-1:0] probes_reg, probes_next;
    logic [1:0] rs_reg, rs_next;
    logic [AW-1:0] rp_reg, rp_next;
    logic ov_reg, ov_next;
    logic [1:0] st_reg, st_next;
    logic [9:0] pos_reg, pos_next;
    logic [10:0] pc_reg, pc_next;
    logic div_start, div_done;
    logic [PW-1:0] div_q;
    logic in_fire;

    ishtab_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (kl_reg - kf_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire = in_valid && in_ready;

    always_comb
    begin
        raddr = first_reg[AW-1:0];
        unique case (state_reg)
            S_RDL: raddr = last_reg[AW-1:0];
            S_RDM: raddr = mid_reg[AW-1:0];
            default: raddr = first_reg[AW-1:0];
        endcase
    end

    assign wr_en = in_fire && (op == ishtab_pkg::OP_APPEND)
                   && (count_reg < CW'(ishtab_pkg::TableDepth));

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[count_reg[AW-1:0]] <= key;
        rdata_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        first_next = first_reg;
        last_next = last_reg;
        mid_next = mid_reg;
        kf_next = kf_reg;
        kl_next = kl_reg;
        prod_next = prod_reg;
        probes_next = probes_reg;
        rs_next = rs_reg;
        rp_next = rp_reg;
        ov_next = ov_reg;
        st_next = st_reg;
        pos_next = pos_reg;
        pc_next = pc_reg;
        div_start = 1'b0;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    probes_next = '0;
                    rp_next = '0;
                    rs_next = ishtab_pkg::ST_NOT_FOUND;
                    state_next = S_EMIT;
                    case (op)
                        ishtab_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            rs_next = ishtab_pkg::ST_OK;
                        end
                        ishtab_pkg::OP_APPEND:
                        begin
                            if (count_reg < CW'(ishtab_pkg::TableDepth))
                            begin
                                rs_next = ishtab_pkg::ST_OK;
                                rp_next = count_reg[AW-1:0];
                                count_next = count_reg + 1'b1;
                            end
                            else
                                rs_next = ishtab_pkg::ST_FULL;
                        end
                        ishtab_pkg::OP_LOOKUP:
                        begin
                            first_next = '0;
                            last_next = $signed({1'b0, count_reg} - (CW+1)'(1));
                            if (count_reg != '0)
                                state_next = S_RDF;
                        end
                        default: ;
                    endcase
                end
            end
            S_RDF:
            begin
                if (first_reg < last_reg)
                    state_next = S_RDL;
                else if (first_reg == last_reg)
                    state_next = S_FIN;
                else
                begin
                    rs_next = ishtab_pkg::ST_NOT_FOUND;
                    rp_next = '0;
                    state_next = S_EMIT;
                end
            end
            S_RDL:
            begin
                kf_next = rdata_reg;
                state_next = S_GETL;
            end
            S_GETL:
            begin
                kl_next = rdata_reg;
                if (probes_reg != '1)
                    probes_next = probes_reg + 1'b1;
                if (key_reg < kf_reg || key_reg > rdata_reg)
                begin
                    rs_next = ishtab_pkg::ST_NOT_FOUND;
                    rp_next = '0;
                    state_next = S_EMIT;
                end
                else if (rdata_reg == kf_reg)
                begin
                    mid_next = first_reg;
                    state_next = S_RDM;
                end
                else
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = PW'(last_reg[CW-1:0] - first_reg[CW-1:0]) * PW'(key_reg - kf_reg);
                state_next = S_GETF;
            end
            S_GETF:
            begin
                div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mid_next = first_reg + $signed({1'b0, div_q[CW-1:0]});
                    state_next = S_RDM;
                end
            end
            S_RDM:
                state_next = S_CMP;
            S_CMP:
            begin
                if (key_reg > rdata_reg)
                begin
                    first_next = mid_reg + $signed((CW+1)'(1));
                    state_next = S_RDF;
                end
                else if (key_reg < rdata_reg)
                begin
                    last_next = mid_reg - $signed((CW+1)'(1));
                    state_next = S_RDF;
                end
                else
                begin
                    rs_next = ishtab_pkg::ST_OK;
                    rp_next = mid_reg[AW-1:0];
                    state_next = S_EMIT;
                end
            end
            S_FIN:
            begin
                // data of entry first arrives now (read issued in S_RDF)
                if (rdata_reg == key_reg)
                begin
                    rs_next = ishtab_pkg::ST_OK;
                    rp_next = first_reg[AW-1:0];
                end
                else
                begin
                    rs_next = ishtab_pkg::ST_NOT_FOUND;
                    rp_next = '0;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    st_next = rs_reg;
                    pos_next = 10'(rp_reg);
                    pc_next = 11'(probes_reg);
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            key_reg <= key;
        first_reg <= first_next;
        last_reg <= last_next;
        mid_reg <= mid_next;
        kf_reg <= kf_next;
        kl_reg <= kl_next;
        prod_reg <= prod_next;
        probes_reg <= probes_next;
        rs_reg <= rs_next;
        rp_reg <= rp_next;
        st_reg <= st_next;
        pos_reg <= pos_next;
        pc_reg <= pc_next;
    end

    assign out_valid = ov_reg;
    assign status = st_reg;
    assign position = pos_reg;
    assign probe_count = pc_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ishtab_pkg::TableDepth))
        else $error("entry count over depth");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result lost under stall");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("accept while busy");
endmodule
